FILE: sv/multichannel_windowed_rms_ratio_assert.svh
// Assertion macros for the windowed RMS ratio block
`ifndef MULTICHANNEL_WINDOWED_RMS_RATIO_ASSERT_SVH
`define MULTICHANNEL_WINDOWED_RMS_RATIO_ASSERT_SVH
`ifndef ASSERT_OFF
`define MWR_ASSERT_IMPL(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define MWR_ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("assertion failed");
`else
`define MWR_ASSERT_IMPL(label, clk, rst_n, prop)
`define MWR_ASSERT_NEXT(label, clk, rst_n, a, b)
`endif
`endif

FILE: sv/mwr_pkg.sv
package mwr_pkg;
    localparam int unsigned COMP_MAX = 6;
    localparam int unsigned ENERGY_W = 33;
    localparam int unsigned SUM_W = 43;
    localparam int unsigned LEVEL_W = 33;

    // configuration register indexes
    localparam logic [10:0] REG_COUNT  = 11'd0;
    localparam logic [10:0] REG_SPLIT  = 11'd1;
    localparam logic [10:0] REG_WINDOW = 11'd2;
    localparam logic [10:0] REG_ENERGY = 11'd3;

    // total and subset enables handed to each lane
    typedef struct packed {
        logic in_total;
        logic in_subset;
    } lane_ctl_t;
endpackage

FILE: sv/mwr_lane.sv
// One component lane: squares a sample and gates it into the two energies
module mwr_lane #(
    parameter int SAMPLE_BITS = 16
) (
    input  logic                            clk,
    input  logic                            load,
    input  logic signed [SAMPLE_BITS-1:0]   sample,
    input  mwr_pkg::lane_ctl_t              ctl,
    output logic [mwr_pkg::ENERGY_W-1:0]    sq_total,
    output logic [mwr_pkg::ENERGY_W-1:0]    sq_subset
);
    logic signed [2*SAMPLE_BITS-1:0] prod;
    logic [2*SAMPLE_BITS-1:0] sq_reg;
    mwr_pkg::lane_ctl_t ctl_reg;

    assign prod = sample * sample;

    // registered square
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            sq_reg  <= prod;
            ctl_reg <= ctl;
        end
    end

    assign sq_total  = ctl_reg.in_total ? mwr_pkg::ENERGY_W'(sq_reg) : '0;
    assign sq_subset = ctl_reg.in_subset ? mwr_pkg::ENERGY_W'(sq_reg) : '0;
endmodule

FILE: sv/mwr_divroot.sv
// Serial unit: restoring divide (43-bit sum by window or Q16 ratio), then optional root
module mwr_divroot (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic                          ratio_mode,
    input  logic                          want_root,
    input  logic [mwr_pkg::SUM_W-1:0]     numer,
    input  logic [mwr_pkg::SUM_W-1:0]     denom,
    output logic                          done,
    output logic [mwr_pkg::LEVEL_W-1:0]   result
);
    localparam int NW = mwr_pkg::SUM_W + 16;   // 59-bit dividend
    localparam int RW = 50;                    // root operand up to 49 bits, even
    localparam int LW = mwr_pkg::LEVEL_W;

    typedef enum logic [1:0] {S_IDLE, S_DIV, S_ROOT, S_DONE} state_t;

    state_t             state_reg;
    logic [5:0]         cnt_reg;
    logic [NW-1:0]      q_reg;
    logic [mwr_pkg::SUM_W:0] rem_reg;
    logic [mwr_pkg::SUM_W-1:0] den_reg;
    logic               root_reg;
    logic               ratio_reg;
    logic [RW-1:0]      x_reg;
    logic [RW/2+1:0]    r_reg;
    logic [RW/2+2:0]    rrem_reg;
    logic [LW-1:0]      res_reg;

    logic [mwr_pkg::SUM_W:0]  rem_sh;
    logic [mwr_pkg::SUM_W:0]  rem_sub;
    logic [LW-1:0]            qsat;
    logic [RW/2+2:0]          rr_sh;
    logic [RW/2+2:0]          trial;

    // final quotient (last bit included), zero on zero divisor, saturated
    function automatic logic [LW-1:0] rsat(input logic [NW-1:0] q,
                                           input logic [mwr_pkg::SUM_W:0] rs,
                                           input logic [mwr_pkg::SUM_W-1:0] d);
        logic [NW-1:0] qf;
        qf = {q[NW-2:0], ~rs[mwr_pkg::SUM_W]};
        if (d == '0)
            return '0;
        return (|qf[NW-1:LW]) ? '1 : qf[LW-1:0];
    endfunction

    always_comb
    begin
        rem_sh  = {rem_reg[mwr_pkg::SUM_W-1:0], q_reg[NW-1]};
        rem_sub = rem_sh - {1'b0, den_reg};
        qsat    = (|q_reg[NW-1:LW]) ? '1 : q_reg[LW-1:0];
        rr_sh   = {rrem_reg[RW/2:0], x_reg[RW-1:RW-2]};
        trial   = {r_reg[RW/2:0], 2'b01};
    end

    // sequencer: 59 divide steps, then 25 root steps when a root is wanted, else a pass-through step
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        root_reg  <= want_root;
                        ratio_reg <= ratio_mode;
                        den_reg   <= denom;
                        rem_reg   <= '0;
                        q_reg     <= ratio_mode ? {numer, 16'd0} : NW'(numer);
                        cnt_reg   <= 6'(NW - 1);
                        state_reg <= S_DIV;
                    end
                end
                S_DIV:
                begin
                    if (!rem_sub[mwr_pkg::SUM_W])
                    begin
                        rem_reg <= rem_sub;
                        q_reg   <= {q_reg[NW-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg <= rem_sh;
                        q_reg   <= {q_reg[NW-2:0], 1'b0};
                    end
                    if (cnt_reg == '0)
                        state_reg <= S_ROOT;
                    else
                        cnt_reg <= cnt_reg - 6'd1;
                    if (cnt_reg == '0)
                        cnt_reg <= 6'(RW/2 - 1);
                end
                S_ROOT:
                begin
                    if (cnt_reg == 6'(RW/2 - 1) && x_reg == '0 && r_reg == '0
                        && rrem_reg == '0)
                    begin
                        // first root step: operand was already loaded from the quotient as the divide finished
                    end
                    if (!root_reg)
                    begin
                        res_reg   <= (den_reg == '0) ? '0 : qsat;
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        if (rr_sh >= trial)
                        begin
                            rrem_reg <= rr_sh - trial;
                            r_reg    <= {r_reg[RW/2:0], 1'b1};
                        end
                        else
                        begin
                            rrem_reg <= rr_sh;
                            r_reg    <= {r_reg[RW/2:0], 1'b0};
                        end
                        x_reg <= {x_reg[RW-3:0], 2'b00};
                        if (cnt_reg == '0)
                            state_reg <= S_DONE;
                        else
                            cnt_reg <= cnt_reg - 6'd1;
                    end
                end
                S_DONE:
                begin
                    if (root_reg)
                        res_reg <= LW'(r_reg);
                    state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
            // root operand is loaded as the divide finishes
            if (state_reg == S_DIV && cnt_reg == '0)
            begin
                x_reg    <= ratio_reg ? RW'({rsat(q_reg, rem_sub, den_reg), 16'd0})
                                      : RW'(rsat(q_reg, rem_sub, den_reg));
                r_reg    <= '0;
                rrem_reg <= '0;
            end
        end
    end

    assign done   = (state_reg == S_DONE);
    assign result = (state_reg == S_DONE && root_reg) ? LW'(r_reg) : res_reg;
endmodule

FILE: sv/multichannel_windowed_rms_ratio.sv
// Flow: an accepted beat passes lane squaring, delay line read and sum update, the
// serial divide steps, the root steps or 1 pass-through step, and a done state, and
// then shows on out_valid.
// One beat at a time: the next beat is taken the cycle after the result
// leaves the output register.
// Reset: sums, fill count, ring index and control clear; registers return to
// count 3, split 0, window 1, root output. Delay lines are not cleared.
`include "multichannel_windowed_rms_ratio_assert.svh"
module multichannel_windowed_rms_ratio #(
    parameter int SAMPLE_BITS = 16,
    parameter int MAX_WINDOW  = 1024
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [10:0]                   cfg_index,
    input  logic [10:0]                   cfg_data,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic signed [SAMPLE_BITS-1:0] sample_0,
    input  logic signed [SAMPLE_BITS-1:0] sample_1,
    input  logic signed [SAMPLE_BITS-1:0] sample_2,
    input  logic signed [SAMPLE_BITS-1:0] sample_3,
    input  logic signed [SAMPLE_BITS-1:0] sample_4,
    input  logic signed [SAMPLE_BITS-1:0] sample_5,
    input  logic                          trace_start,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [mwr_pkg::LEVEL_W-1:0]   level
);
    localparam int AW = $clog2(MAX_WINDOW);
    localparam int CW = $clog2(MAX_WINDOW + 1);
    localparam int EW = mwr_pkg::ENERGY_W;
    localparam int SW = mwr_pkg::SUM_W;
    localparam int NC = mwr_pkg::COMP_MAX;

    typedef enum logic [2:0] {P_IDLE, P_SQ, P_MEM, P_SUM, P_CALC, P_OUT} state_t;

    // configuration
    logic [2:0]  count_reg;
    logic [2:0]  split_reg;
    logic [10:0] window_reg;
    logic        energy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= 3'd3;
            split_reg  <= 3'd0;
            window_reg <= 11'd1;
            energy_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                mwr_pkg::REG_COUNT:  count_reg  <= cfg_data[2:0];
                mwr_pkg::REG_SPLIT:  split_reg  <= cfg_data[2:0];
                mwr_pkg::REG_WINDOW: window_reg <= cfg_data;
                mwr_pkg::REG_ENERGY: energy_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // effective count and window length
    logic [2:0]    count_eff;
    logic [CW-1:0] len_eff;
    always_comb
    begin
        count_eff = (count_reg == 3'd0) ? 3'd1 :
                    (count_reg > 3'(NC)) ? 3'(NC) : count_reg;
        if (window_reg == '0)
            len_eff = CW'(1);
        else if ({21'd0, window_reg} > 32'(MAX_WINDOW))
            len_eff = CW'(MAX_WINDOW);
        else
            len_eff = CW'(window_reg);
    end

    state_t state_reg;
    wire take = in_valid && !in_stall;
    assign in_stall = (state_reg != P_IDLE);

    // lanes
    logic signed [SAMPLE_BITS-1:0] smp [NC];
    logic [EW-1:0] lt [NC];
    logic [EW-1:0] ls [NC];
    assign smp[0] = sample_0;
    assign smp[1] = sample_1;
    assign smp[2] = sample_2;
    assign smp[3] = sample_3;
    assign smp[4] = sample_4;
    assign smp[5] = sample_5;

    genvar g;
    generate
        for (g = 0; g < NC; g++)
        begin : g_lane
            mwr_pkg::lane_ctl_t c;
            assign c.in_total  = (3'(g) < count_eff);
            assign c.in_subset = (3'(g) < count_eff) && (3'(g) >= split_reg);
            mwr_lane #(.SAMPLE_BITS(SAMPLE_BITS)) u_lane (
                .clk(clk), .load(take), .sample(smp[g]), .ctl(c),
                .sq_total(lt[g]), .sq_subset(ls[g])
            );
        end
    endgenerate

    // merge: combinational adder chain over the lanes
    logic [EW-1:0] m_tot, m_sub;
    always_comb
    begin
        m_tot = '0;
        m_sub = '0;
        for (int i = 0; i < NC; i++)
        begin
            m_tot = m_tot + lt[i];
            m_sub = m_sub + ls[i];
        end
    end

    // delay lines
    logic [EW-1:0] tline [MAX_WINDOW];
    logic [EW-1:0] sline [MAX_WINDOW];
    logic [EW-1:0] told_reg, sold_reg, etot_reg, esub_reg;
    logic [AW-1:0] wpos_reg;
    logic [CW-1:0] seen_reg;
    logic [SW-1:0] tsum_reg, ssum_reg;
    logic          trace_reg;
    logic [AW-1:0] old_pos;
    // ring index of the oldest entry, wrapped at the line depth
    assign old_pos = (CW'(wpos_reg) >= len_eff) ? AW'(CW'(wpos_reg) - len_eff)
                   : AW'(CW'(wpos_reg) + CW'(MAX_WINDOW) - len_eff);

    always_ff @(posedge clk)
    begin
        if (state_reg == P_SQ)
        begin
            told_reg <= tline[old_pos];
            sold_reg <= sline[old_pos];
            etot_reg <= m_tot;
            esub_reg <= m_sub;
        end
        if (state_reg == P_MEM)
        begin
            tline[wpos_reg] <= etot_reg;
            sline[wpos_reg] <= esub_reg;
        end
    end

    logic div_done;
    logic [mwr_pkg::LEVEL_W-1:0] div_res;
    logic [mwr_pkg::LEVEL_W-1:0] level_reg;

    // control and sums
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= P_IDLE;
            wpos_reg  <= '0;
            seen_reg  <= '0;
            tsum_reg  <= '0;
            ssum_reg  <= '0;
            trace_reg <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                P_IDLE:
                    if (take)
                    begin
                        trace_reg <= trace_start;
                        state_reg <= P_SQ;
                    end
                P_SQ:
                begin
                    if (trace_reg)
                    begin
                        tsum_reg <= '0;
                        ssum_reg <= '0;
                        seen_reg <= '0;
                    end
                    state_reg <= P_MEM;
                end
                P_MEM:
                begin
                    if (seen_reg >= len_eff)
                    begin
                        tsum_reg <= tsum_reg - SW'(told_reg) + SW'(etot_reg);
                        ssum_reg <= ssum_reg - SW'(sold_reg) + SW'(esub_reg);
                    end
                    else
                    begin
                        tsum_reg <= tsum_reg + SW'(etot_reg);
                        ssum_reg <= ssum_reg + SW'(esub_reg);
                    end
                    wpos_reg <= (wpos_reg == AW'(MAX_WINDOW - 1)) ? '0 : wpos_reg + AW'(1);
                    if (seen_reg < CW'(MAX_WINDOW))
                        seen_reg <= seen_reg + CW'(1);
                    state_reg <= P_SUM;
                end
                P_SUM: state_reg <= P_CALC;
                P_CALC:
                    if (div_done)
                    begin
                        level_reg <= div_res;
                        state_reg <= P_OUT;
                    end
                P_OUT:
                    if (!out_stall)
                        state_reg <= P_IDLE;
                default: state_reg <= P_IDLE;
            endcase
        end
    end

    wire ratio = (split_reg != 3'd0);
    mwr_divroot u_div (
        .clk(clk), .rst_n(rst_n), .start(state_reg == P_SUM),
        .ratio_mode(ratio), .want_root(!energy_reg),
        .numer(ratio ? ssum_reg : tsum_reg),
        .denom(ratio ? tsum_reg : SW'(len_eff)),
        .done(div_done), .result(div_res)
    );

    assign out_valid = (state_reg == P_OUT);
    assign level     = level_reg;

    `MWR_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid)
    `MWR_ASSERT_IMPL(a_no_take_busy, clk, rst_n, out_valid |-> in_stall)
    `MWR_ASSERT_NEXT(a_seen_sat, clk, rst_n, 1'b1, seen_reg <= CW'(MAX_WINDOW))
endmodule
